>>> rtl/core/ffc_pkg.sv
// Shared definitions for the four-function key calculator.
// Key and operator codes, widths and the controller/datapath interface structs.
// No dependencies.
package ffc_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned OutWidth      = 32;
  localparam int unsigned OpcodeWidth   = 3;
  localparam int unsigned DigitWidth    = 4;
  localparam int unsigned PendWidth     = 3;

  // key codes
  localparam logic [OpcodeWidth-1:0] KeyDigit  = 3'd0;
  localparam logic [OpcodeWidth-1:0] KeyClear  = 3'd1;
  localparam logic [OpcodeWidth-1:0] KeyEquals = 3'd2;
  localparam logic [OpcodeWidth-1:0] KeyAdd    = 3'd3;
  localparam logic [OpcodeWidth-1:0] KeySub    = 3'd4;
  localparam logic [OpcodeWidth-1:0] KeyMul    = 3'd5;
  localparam logic [OpcodeWidth-1:0] KeyDiv    = 3'd6;

  // pending operator codes
  localparam logic [PendWidth-1:0] PendNone = 3'd0;
  localparam logic [PendWidth-1:0] PendAdd  = 3'd1;
  localparam logic [PendWidth-1:0] PendSub  = 3'd2;
  localparam logic [PendWidth-1:0] PendMul  = 3'd3;
  localparam logic [PendWidth-1:0] PendDiv  = 3'd4;

  typedef struct packed {
    logic key;       // key transfer: update calculator state
    logic mul_step;  // one shift-add step
    logic div_step;  // one restoring division step
    logic last;      // final iteration, write accumulator
    logic load_out;  // capture shown value into output register
  } cmd_t;

  typedef struct packed {
    logic need_mul;
    logic need_div;
  } sts_t;

endpackage

>>> rtl/core/ffc_ctrl.sv
// Controller for the four-function key calculator.
// Sequences key transfer, iterative multiply/divide and result delivery. Uses ffc_pkg.
module ffc_ctrl import ffc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.key = 1'b1;
          cnt_d     = CntW'(VALUE_WIDTH - 1);
          if (sts_i.need_mul) begin
            state_d = StMul;
          end else if (sts_i.need_div) begin
            state_d = StDiv;
          end else begin
            state_d = StDone;
          end
        end
      end
      StMul, StDiv: begin
        cmd_o.mul_step = (state_q == StMul);
        cmd_o.div_step = (state_q == StDiv);
        cmd_o.last     = (cnt_q == '0);
        if (cnt_q == '0) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDone: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/ffc_dp.sv
// Datapath for the four-function key calculator.
// Calculator state, digit entry, add/subtract, shared shift-add multiply and
// restoring divide registers, and the output payload register. Uses ffc_pkg.
module ffc_dp import ffc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [OpcodeWidth-1:0]  opcode_i,
  input  logic [DigitWidth-1:0]   digit_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  output logic signed [OutWidth-1:0] shown_value_o,
  output logic [PendWidth-1:0]    pending_operator_o
);

  localparam int unsigned W = VALUE_WIDTH;

  logic [W-1:0]         acc_q, entry_q;
  logic [PendWidth-1:0] pend_q;
  logic                 entering_q, evaluated_q;

  // shared iteration registers: multiplicand/divisor, multiplier/quotient, product/remainder
  logic [W-1:0] opa_q, opb_q, part_q;
  logic         neg_q;

  logic         is_op, applies;
  logic [W-1:0] digit_base, base_x10, entry_next, apply_val;
  logic [W-1:0] mag_acc, mag_entry;
  logic [W-1:0] mul_sum;
  logic [W:0]   div_shift, div_diff;
  logic [W-1:0] div_rem, div_quo, div_res;
  logic [W-1:0] shown_w;
  logic [OutWidth-1:0] shown_ext;

  assign is_op = (opcode_i == KeyAdd) || (opcode_i == KeySub) ||
                 (opcode_i == KeyMul) || (opcode_i == KeyDiv);
  assign applies = entering_q && (is_op || (opcode_i == KeyEquals));

  assign sts_o.need_mul = applies && (pend_q == PendMul);
  assign sts_o.need_div = applies && (pend_q == PendDiv) && (entry_q != '0);

  // digit entry: entry*10 plus or minus the digit, toward the entry's sign
  assign digit_base = (evaluated_q || !entering_q) ? '0 : entry_q;
  assign base_x10   = (digit_base << 3) + (digit_base << 1);
  assign entry_next = digit_base[W-1] ? base_x10 - W'(digit_i) : base_x10 + W'(digit_i);

  // apply without iteration; division by zero and no operator both take the entry
  always_comb begin
    case (pend_q)
      PendAdd: apply_val = acc_q + entry_q;
      PendSub: apply_val = acc_q - entry_q;
      default: apply_val = entry_q;
    endcase
  end

  assign mag_acc   = acc_q[W-1]   ? W'(-acc_q)   : acc_q;
  assign mag_entry = entry_q[W-1] ? W'(-entry_q) : entry_q;

  assign mul_sum = part_q + (opb_q[0] ? opa_q : '0);

  assign div_shift = {part_q, opb_q[W-1]};
  assign div_diff  = div_shift - {1'b0, opa_q};
  assign div_rem   = div_diff[W] ? div_shift[W-1:0] : div_diff[W-1:0];
  assign div_quo   = {opb_q[W-2:0], ~div_diff[W]};
  assign div_res   = neg_q ? W'(-div_quo) : div_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      entry_q     <= '0;
      pend_q      <= PendNone;
      entering_q  <= 1'b0;
      evaluated_q <= 1'b0;
    end else if (cmd_i.key) begin
      case (opcode_i)
        KeyDigit: begin
          if (evaluated_q) begin
            acc_q  <= '0;
            pend_q <= PendNone;
          end
          evaluated_q <= 1'b0;
          entering_q  <= 1'b1;
          entry_q     <= entry_next;
        end
        KeyClear: begin
          acc_q       <= '0;
          entry_q     <= '0;
          pend_q      <= PendNone;
          entering_q  <= 1'b0;
          evaluated_q <= 1'b0;
        end
        KeyEquals, KeyAdd, KeySub, KeyMul, KeyDiv: begin
          if (applies && !sts_o.need_mul && !sts_o.need_div) begin
            acc_q <= apply_val;
          end
          entering_q <= 1'b0;
          if (opcode_i == KeyEquals) begin
            evaluated_q <= 1'b1;
            pend_q      <= PendNone;
          end else begin
            evaluated_q <= 1'b0;
            pend_q      <= PendWidth'(opcode_i - KeyEquals);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.last && cmd_i.mul_step) begin
      acc_q <= mul_sum;
    end else if (cmd_i.last && cmd_i.div_step) begin
      acc_q <= div_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key) begin
      if (sts_o.need_div) begin
        opa_q  <= mag_entry;
        opb_q  <= mag_acc;
        part_q <= '0;
        neg_q  <= acc_q[W-1] ^ entry_q[W-1];
      end else begin
        opa_q  <= acc_q;
        opb_q  <= entry_q;
        part_q <= '0;
        neg_q  <= 1'b0;
      end
    end else if (cmd_i.mul_step) begin
      part_q <= mul_sum;
      opa_q  <= opa_q << 1;
      opb_q  <= opb_q >> 1;
    end else if (cmd_i.div_step) begin
      part_q <= div_rem;
      opb_q  <= div_quo;
    end
  end

  assign shown_w = entering_q ? entry_q : acc_q;

  generate
    if (W >= OutWidth) begin : g_trunc
      assign shown_ext = shown_w[OutWidth-1:0];
    end else begin : g_sext
      assign shown_ext = {{(OutWidth - W){shown_w[W-1]}}, shown_w};
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      shown_value_o      <= shown_ext;
      pending_operator_o <= pend_q;
    end
  end

endmodule

>>> rtl/core/four_function_calculator_keys_top.sv
// Four-function key calculator, immediate execution, left to right, no precedence.
// A key with no multiply or divide to apply passes from idle to done and back to idle;
// with one, it runs through the multiply or divide state first: the shift-add multiplier
// and the restoring divider share one set of registers and retire one bit per cycle. The
// next key is taken while the previous result still waits in the output register.
// Uses ffc_pkg, ffc_ctrl and ffc_dp.
module four_function_calculator_keys_top import ffc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [OpcodeWidth-1:0]     opcode_i,
  input  logic [DigitWidth-1:0]      digit_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OutWidth-1:0] shown_value_o,
  output logic [PendWidth-1:0]       pending_operator_o
);

  cmd_t cmd;
  sts_t sts;

  ffc_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffc_dp #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .opcode_i          (opcode_i),
    .digit_i           (digit_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .shown_value_o     (shown_value_o),
    .pending_operator_o(pending_operator_o)
  );

endmodule

>>> dv/four_function_calculator_keys_top_tb.sv
// Self-checking testbench for four_function_calculator_keys_top: directed key table, then random
// key sequences, each transfer checked against a built-in calculator model.
// Depends on ffc_pkg and the RTL under rtl/core.
module four_function_calculator_keys_top_tb import ffc_pkg::*; ();

  localparam int unsigned VW = ValueWidthDef;
  localparam logic [OpcodeWidth-1:0] KeyUnused = 3'd7;
  localparam int RandomKeys  = 1500;
  localparam int CycleLimit  = 2000000;
  localparam int DrainCycles = 80;

  typedef struct packed {
    logic [OpcodeWidth-1:0]     op;
    logic [DigitWidth-1:0]      dig;
    logic                       typed;
    logic signed [OutWidth-1:0] shown;
    logic [PendWidth-1:0]       pend;
  } key_row_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] shown;
    logic [PendWidth-1:0]       pend;
  } display_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [OpcodeWidth-1:0]     opcode_i = KeyDigit;
  logic [DigitWidth-1:0]      digit_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [OutWidth-1:0] shown_value_o;
  logic [PendWidth-1:0]       pending_operator_o;

  four_function_calculator_keys_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .digit_i            (digit_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .shown_value_o      (shown_value_o),
    .pending_operator_o (pending_operator_o)
  );

  key_row_t key_q[$];
  display_t display_q[$];
  int       errors = 0;
  int       cycles = 0;
  int       keys_taken = 0;

  // calculator state
  logic [VW-1:0]        acc_q = '0;
  logic [VW-1:0]        entry_q = '0;
  logic [PendWidth-1:0] pend_q = PendNone;
  logic                 entering_q = 1'b0;
  logic                 evaluated_q = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [VW-1:0] trunc_quotient(input logic [VW-1:0] a,
                                                   input logic [VW-1:0] b);
    logic [VW-1:0] mag_a;
    logic [VW-1:0] mag_b;
    logic [VW-1:0] q;
    mag_a = a[VW-1] ? -a : a;
    mag_b = b[VW-1] ? -b : b;
    q = mag_a / mag_b;
    return (a[VW-1] ^ b[VW-1]) ? -q : q;
  endfunction

  function automatic logic [VW-1:0] combine(input logic [PendWidth-1:0] op,
                                            input logic [VW-1:0] a, input logic [VW-1:0] e);
    case (op)
      PendAdd: return a + e;
      PendSub: return a - e;
      PendMul: return a * e;
      // a zero divisor leaves the entry, which is zero, in the accumulator
      PendDiv: return (e != '0) ? trunc_quotient(a, e) : e;
      default: return e;
    endcase
  endfunction

  task automatic press_key(input logic [OpcodeWidth-1:0] op, input logic [DigitWidth-1:0] dig,
                           output display_t shown_out);
    logic [VW-1:0] v;
    case (op)
      KeyDigit: begin
        if (evaluated_q) begin
          acc_q = '0;
          pend_q = PendNone;
          evaluated_q = 1'b0;
          entering_q = 1'b0;
        end
        if (!entering_q) begin
          entry_q = '0;
          entering_q = 1'b1;
        end
        if (entry_q[VW-1]) entry_q = entry_q * VW'(10) - VW'(dig);
        else entry_q = entry_q * VW'(10) + VW'(dig);
      end
      KeyClear: begin
        acc_q = '0;
        entry_q = '0;
        pend_q = PendNone;
        entering_q = 1'b0;
        evaluated_q = 1'b0;
      end
      KeyEquals, KeyAdd, KeySub, KeyMul, KeyDiv: begin
        if (entering_q) begin
          acc_q = combine(pend_q, acc_q, entry_q);
          entering_q = 1'b0;
        end
        evaluated_q = (op == KeyEquals);
        case (op)
          KeyAdd:  pend_q = PendAdd;
          KeySub:  pend_q = PendSub;
          KeyMul:  pend_q = PendMul;
          KeyDiv:  pend_q = PendDiv;
          default: pend_q = PendNone;
        endcase
      end
      default: ;
    endcase
    v = entering_q ? entry_q : acc_q;
    shown_out.shown = OutWidth'($signed(v));
    shown_out.pend = pend_q;
  endtask

  task automatic add_row(input logic [OpcodeWidth-1:0] op, input logic [DigitWidth-1:0] dig,
                         input logic typed, input logic signed [OutWidth-1:0] shown,
                         input logic [PendWidth-1:0] pend);
    key_row_t row;
    row.op = op;
    row.dig = dig;
    row.typed = typed;
    row.shown = shown;
    row.pend = pend;
    key_q.push_back(row);
  endtask

  task automatic add_key(input logic [OpcodeWidth-1:0] op, input logic [DigitWidth-1:0] dig);
    add_row(op, dig, 1'b0, '0, PendNone);
  endtask

  task automatic add_number(input string s);
    for (int i = 0; i < s.len(); i++) add_key(KeyDigit, DigitWidth'(s.getc(i) - "0"));
  endtask

  function automatic logic [OpcodeWidth-1:0] any_operator();
    return OpcodeWidth'(KeyAdd + $urandom_range(0, 3));
  endfunction

  task automatic build_random_keys();
    int r;
    int n;
    int t;
    while (key_q.size() < RandomKeys + 25) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // most negative value divided by minus one wraps back to itself
        add_key(KeyClear, DigitWidth'($urandom_range(0, 15)));
        add_number("2147483648");
        add_key(KeyDiv, DigitWidth'($urandom_range(0, 15)));
        add_number("4294967295");
        add_key(KeyEquals, DigitWidth'($urandom_range(0, 15)));
      end else if (r < 80) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        repeat (n) begin
          add_key(KeyDigit, ($urandom_range(0, 99) < 3) ? DigitWidth'($urandom_range(10, 15))
                                                        : DigitWidth'($urandom_range(0, 9)));
        end
        t = $urandom_range(0, 99);
        if (t < 70) add_key(any_operator(), DigitWidth'($urandom_range(0, 15)));
        else if (t < 95) add_key(KeyEquals, DigitWidth'($urandom_range(0, 15)));
      end else if (r < 88) begin
        add_key(($urandom_range(0, 2) == 0) ? KeyEquals : any_operator(),
                DigitWidth'($urandom_range(0, 15)));
      end else if (r < 94) begin
        add_key(KeyClear, DigitWidth'($urandom_range(0, 15)));
      end else if (r < 97) begin
        add_key(KeyUnused, DigitWidth'($urandom_range(0, 15)));
      end else begin
        add_key(OpcodeWidth'($urandom_range(0, 7)), DigitWidth'($urandom_range(0, 15)));
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 150);
  endfunction

  initial begin : key_source
    key_row_t row;
    display_t want;
    int gap;
    add_row(KeyEquals, 4'd0, 1'b1, 0, PendNone);
    add_row(KeyDigit, 4'd7, 1'b1, 7, PendNone);      // digit after equals starts afresh
    add_row(KeyAdd, 4'd0, 1'b1, 7, PendAdd);
    add_row(KeyDigit, 4'd5, 1'b1, 5, PendAdd);
    add_row(KeySub, 4'd0, 1'b1, 12, PendSub);
    add_row(KeyDigit, 4'd3, 1'b1, 3, PendSub);
    add_row(KeyMul, 4'd0, 1'b1, 9, PendMul);
    add_row(KeyDigit, 4'd4, 1'b1, 4, PendMul);
    add_row(KeyDiv, 4'd0, 1'b1, 36, PendDiv);
    add_row(KeyDigit, 4'd0, 1'b1, 0, PendDiv);
    add_row(KeyEquals, 4'd0, 1'b1, 0, PendNone);     // division by zero
    add_row(KeyClear, 4'd9, 1'b1, 0, PendNone);
    add_row(KeyDigit, 4'd15, 1'b1, 15, PendNone);    // digit above nine used as given
    add_row(KeyDigit, 4'd15, 1'b1, 165, PendNone);
    add_row(KeyUnused, 4'd5, 1'b1, 165, PendNone);   // unused opcode changes nothing
    add_row(KeyClear, 4'd0, 1'b1, 0, PendNone);
    add_row(KeySub, 4'd0, 1'b1, 0, PendSub);
    add_row(KeyDigit, 4'd9, 1'b1, 9, PendSub);
    add_row(KeyDiv, 4'd0, 1'b1, -9, PendDiv);
    add_row(KeyDigit, 4'd2, 1'b1, 2, PendDiv);
    add_row(KeyEquals, 4'd0, 1'b1, -4, PendNone);    // truncates toward zero
    add_row(KeyMul, 4'd0, 1'b1, -4, PendMul);
    add_key(KeyDigit, 4'd8);
    add_key(KeyAdd, 4'd0);
    add_key(KeyDiv, 4'd0);
    build_random_keys();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (key_q.size() > 0) begin
      row = key_q.pop_front();
      gap = pick_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      opcode_i <= row.op;
      digit_i <= row.dig;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      press_key(row.op, row.dig, want);
      if (row.typed) begin
        want.shown = row.shown;
        want.pend = row.pend;
      end
      display_q.push_back(want);
      keys_taken++;
    end
    in_valid_i <= 1'b0;
    while (display_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : display_sink
    int r;
    bit held_off;
    held_off = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held_off && keys_taken >= 300) begin
        // hold off long enough for the input side to back up
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_ready_i <= 1'b1;
          repeat ($urandom_range(5, 60)) @(posedge clk_i);
        end else if (r < 92) begin
          repeat ($urandom_range(5, 40)) begin
            out_ready_i <= ($urandom_range(0, 3) != 0);
            @(posedge clk_i);
          end
        end else begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : display_check
    display_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (display_q.size() == 0) begin
        $error("shown_value: no key waiting, got %0d", shown_value_o);
        errors++;
      end else begin
        want = display_q.pop_front();
        if (shown_value_o !== want.shown) begin
          $error("shown_value: expected %0d, got %0d", want.shown, shown_value_o);
          errors++;
        end
        if (pending_operator_o !== want.pend) begin
          $error("pending_operator: expected %0d, got %0d", want.pend, pending_operator_o);
          errors++;
        end
      end
    end
  end

endmodule
